### rtl/core/cfmp_pkg.sv
// Shared types, constants and table functions for the chemical formula mass parser.
// Depends on nothing; every other file of the block takes names from here.
`default_nettype none

package cfmp_pkg;

    localparam int ELEM_COUNT = 30;
    localparam int ELEM_W     = 5;
    localparam int COUNT_W    = 31;
    localparam int MASS_W     = 40;
    localparam int POS_W      = 16;
    localparam int CHAR_W     = 8;
    localparam int TOTAL_W    = 64;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;
    localparam int Q_CW       = 3;

    // Table masses are exact in units of 1e-11.
    localparam longint unsigned UNIT_SCALE = 64'd100000000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        PH_UPPER,
        PH_SYMBOL,
        PH_DIGITS
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_BAD_CHAR   = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_COUNT_BIG  = 3'd4,
        ST_COUNT_ZERO = 3'd5
    } status_t;

    // One command from the parser to the mass pipeline.
    typedef struct packed {
        logic                add_en;
        logic [ELEM_W-1:0]   elem;
        logic [COUNT_W-1:0]  count;
        logic                fin;
        status_t             status;
        logic [POS_W-1:0]    pos;
    } cmd_t;

    // Up to two commands may be written in one cycle: a closed group, then the final one.
    typedef struct packed {
        logic a_en;
        cmd_t a;
        logic b_en;
        cmd_t b;
    } push_t;

    typedef struct packed {
        logic              found;
        logic [ELEM_W-1:0] idx;
    } lookup_t;

    // Uppercase letter as offset from 'A'.
    localparam logic [4:0] ELEM_UP [ELEM_COUNT] = '{
        5'd7,  5'd7,  5'd11, 5'd1,  5'd1,  5'd2,  5'd13, 5'd14, 5'd5,  5'd13,
        5'd13, 5'd12, 5'd0,  5'd18, 5'd15, 5'd18, 5'd2,  5'd0,  5'd10, 5'd2,
        5'd12, 5'd5,  5'd2,  5'd13, 5'd2,  5'd25, 5'd18, 5'd1,  5'd12, 5'd8
    };

    // Lowercase letter as offset from 'a' plus one, zero for none.
    localparam logic [4:0] ELEM_LO [ELEM_COUNT] = '{
        5'd0,  5'd5,  5'd9,  5'd5,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd5,
        5'd1,  5'd7,  5'd12, 5'd9,  5'd0,  5'd0,  5'd12, 5'd18, 5'd0,  5'd1,
        5'd14, 5'd5,  5'd15, 5'd9,  5'd21, 5'd14, 5'd5,  5'd18, 5'd15, 5'd0
    };

    // H He Li Be B C N O F Ne Na Mg Al Si P S Cl Ar K Ca Mn Fe Co Ni Cu Zn Se Br Mo I
    localparam longint unsigned ELEM_SCALED [ELEM_COUNT] = '{
        64'd100782503207,   64'd400260325415,   64'd701600455000,
        64'd901218220000,   64'd1100930540000,  64'd1200000000000,
        64'd1400307400480,  64'd1599491461956,  64'd1899840322000,
        64'd1999244017540,  64'd2298976928090,  64'd2398504170000,
        64'd2698153863000,  64'd2797692653250,  64'd3097376163000,
        64'd3197207100000,  64'd3496885268000,  64'd3996238312250,
        64'd3896370668000,  64'd3996259098000,  64'd5493804510000,
        64'd5593493750000,  64'd5893319500000,  64'd5793534290000,
        64'd6292959750000,  64'd6392914220000,  64'd7991652130000,
        64'd7891833710000,  64'd9790540820000,  64'd12690447300000
    };

    function automatic lookup_t elem_lookup(
        input logic [4:0] up,
        input logic [4:0] lo,
        input logic       too_long
    );
        lookup_t r;
        r = '0;
        for (int i = 0; i < ELEM_COUNT; i++)
        begin
            if (!too_long && ELEM_UP[i] == up && ELEM_LO[i] == lo)
            begin
                r.found = 1'b1;
                r.idx   = ELEM_W'(i);
            end
        end
        return r;
    endfunction

    // Convert a table mass to fixed point, rounding halves up; used for constants only.
    function automatic logic [MASS_W-1:0] fixed_mass(
        input longint unsigned v,
        input int              fb
    );
        longint unsigned res;
        longint unsigned r;
        res = v / UNIT_SCALE;
        r   = v % UNIT_SCALE;
        for (int i = 0; i < fb; i++)
        begin
            res = res << 1;
            r   = r << 1;
            if (r >= UNIT_SCALE)
            begin
                res = res | 64'd1;
                r   = r - UNIT_SCALE;
            end
        end
        r = r << 1;
        if (r >= UNIT_SCALE)
        begin
            res = res + 64'd1;
        end
        return MASS_W'(res);
    endfunction

endpackage

`default_nettype wire

### rtl/core/cfmp_front.sv
// Parser front end: classifies characters, tracks groups and errors, issues commands.
// Depends on cfmp_pkg.
`default_nettype none

module cfmp_front #(
    parameter longint MAX_LENGTH = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [cfmp_pkg::CHAR_W-1:0]   in_char,
    input  wire logic                          in_last,
    input  wire logic                          in_none,
    output cfmp_pkg::push_t                    push
);

    localparam int IDX_W  = $clog2(MAX_LENGTH);
    localparam int FPOS_W = (IDX_W < cfmp_pkg::POS_W) ? IDX_W : cfmp_pkg::POS_W;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LENGTH - 1);

    cfmp_pkg::phase_t                 phase_reg, phase_next, phase_mid;
    logic [4:0]                       up_reg, up_next, up_mid;
    logic [4:0]                       lo_reg, lo_next, lo_mid;
    logic                             long_reg, long_next, long_mid;
    logic [cfmp_pkg::COUNT_W-1:0]     count_reg, count_next, count_mid;
    logic                             ovf_reg, ovf_next, ovf_mid;
    cfmp_pkg::status_t                err_reg, err_next, err_mid;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [FPOS_W-1:0]                fpos_reg, fpos_next, fpos_mid;

    logic                             accept;
    logic                             is_up, is_low, is_dig;
    logic [4:0]                       up_code, lo_code;
    logic [cfmp_pkg::COUNT_W+3:0]     count_ext, count_ten;
    logic                             count_big;
    cfmp_pkg::lookup_t                cur_lu, mid_lu;
    logic                             start_sym, bad_char, follow;
    logic                             a_en;
    logic [cfmp_pkg::COUNT_W-1:0]     a_count;
    logic                             b_add;
    logic [cfmp_pkg::COUNT_W-1:0]     b_count;
    cfmp_pkg::status_t                fin_status;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        is_up  = in_char inside {[8'h41:8'h5A]};
        is_low = in_char inside {[8'h61:8'h7A]};
        is_dig = in_char inside {[8'h30:8'h39]};
    end

    assign up_code   = 5'(in_char - 8'h41);
    assign lo_code   = 5'(in_char - 8'h60);
    assign count_ext = {4'b0, count_reg};
    assign count_ten = (count_ext << 3) + (count_ext << 1)
                       + (cfmp_pkg::COUNT_W + 4)'(in_char[3:0]);
    assign count_big = count_ten > {4'b0, cfmp_pkg::COUNT_MAX};

    assign cur_lu = cfmp_pkg::elem_lookup(up_reg, lo_reg, long_reg);

    // Character step: state after this byte, and a closed group if any.
    always_comb
    begin
        phase_mid = phase_reg;
        up_mid    = up_reg;
        lo_mid    = lo_reg;
        long_mid  = long_reg;
        count_mid = count_reg;
        ovf_mid   = ovf_reg;
        err_mid   = err_reg;
        fpos_mid  = fpos_reg;
        a_en      = 1'b0;
        a_count   = count_reg;
        start_sym = 1'b0;
        bad_char  = 1'b0;
        follow    = 1'b0;
        if (!in_none && err_reg == cfmp_pkg::ST_OK)
        begin
            case (phase_reg)
                cfmp_pkg::PH_UPPER:
                begin
                    follow = 1'b1;
                end
                cfmp_pkg::PH_SYMBOL:
                begin
                    if (is_low)
                    begin
                        if (lo_reg != 5'd0)
                            long_mid = 1'b1;
                        else
                            lo_mid = lo_code;
                    end
                    else if (!cur_lu.found)
                    begin
                        err_mid  = cfmp_pkg::ST_UNKNOWN;
                        fpos_mid = '0;
                    end
                    else if (is_dig)
                    begin
                        phase_mid = cfmp_pkg::PH_DIGITS;
                        count_mid = cfmp_pkg::COUNT_W'(in_char[3:0]);
                        ovf_mid   = 1'b0;
                    end
                    else
                    begin
                        a_en    = 1'b1;
                        a_count = cfmp_pkg::COUNT_W'(1);
                        follow  = 1'b1;
                    end
                end
                cfmp_pkg::PH_DIGITS:
                begin
                    if (is_dig)
                    begin
                        if (!ovf_reg)
                        begin
                            if (count_big)
                                ovf_mid = 1'b1;
                            else
                                count_mid = cfmp_pkg::COUNT_W'(count_ten);
                        end
                    end
                    else if (ovf_reg)
                    begin
                        err_mid  = cfmp_pkg::ST_COUNT_BIG;
                        fpos_mid = '0;
                    end
                    else if (count_reg == '0)
                    begin
                        err_mid  = cfmp_pkg::ST_COUNT_ZERO;
                        fpos_mid = '0;
                    end
                    else
                    begin
                        a_en    = 1'b1;
                        a_count = count_reg;
                        follow  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (follow)
            begin
                start_sym = is_up;
                bad_char  = !is_up;
            end
            if (start_sym)
            begin
                phase_mid = cfmp_pkg::PH_SYMBOL;
                up_mid    = up_code;
                lo_mid    = 5'd0;
                long_mid  = 1'b0;
            end
            if (bad_char)
            begin
                err_mid  = cfmp_pkg::ST_BAD_CHAR;
                fpos_mid = idx_reg[FPOS_W-1:0];
            end
        end
    end

    assign mid_lu = cfmp_pkg::elem_lookup(up_mid, lo_mid, long_mid);

    // End of formula: close the open group and settle the status.
    always_comb
    begin
        fin_status = err_mid;
        b_add      = 1'b0;
        b_count    = count_mid;
        if (err_mid == cfmp_pkg::ST_OK)
        begin
            case (phase_mid)
                cfmp_pkg::PH_SYMBOL:
                begin
                    if (mid_lu.found)
                    begin
                        b_add   = 1'b1;
                        b_count = cfmp_pkg::COUNT_W'(1);
                    end
                    else
                    begin
                        fin_status = cfmp_pkg::ST_UNKNOWN;
                    end
                end
                cfmp_pkg::PH_DIGITS:
                begin
                    if (ovf_mid)
                        fin_status = cfmp_pkg::ST_COUNT_BIG;
                    else if (count_mid == '0)
                        fin_status = cfmp_pkg::ST_COUNT_ZERO;
                    else
                        b_add = 1'b1;
                end
                cfmp_pkg::PH_UPPER:
                begin
                    fin_status = cfmp_pkg::ST_EMPTY;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Command outputs.
    always_comb
    begin
        push.a_en       = accept && a_en;
        push.a.add_en   = 1'b1;
        push.a.elem     = cur_lu.idx;
        push.a.count    = a_count;
        push.a.fin      = 1'b0;
        push.a.status   = cfmp_pkg::ST_OK;
        push.a.pos      = '0;
        push.b_en       = accept && in_last;
        push.b.add_en   = b_add;
        push.b.elem     = mid_lu.idx;
        push.b.count    = b_count;
        push.b.fin      = 1'b1;
        push.b.status   = fin_status;
        push.b.pos      = (fin_status == cfmp_pkg::ST_BAD_CHAR)
                          ? cfmp_pkg::POS_W'(fpos_mid) : '0;
    end

    // Next state: take the step, or return to the start after the last item.
    always_comb
    begin
        phase_next = phase_reg;
        up_next    = up_reg;
        lo_next    = lo_reg;
        long_next  = long_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        err_next   = err_reg;
        idx_next   = idx_reg;
        fpos_next  = fpos_reg;
        if (accept)
        begin
            if (in_last)
            begin
                phase_next = cfmp_pkg::PH_UPPER;
                up_next    = 5'd0;
                lo_next    = 5'd0;
                long_next  = 1'b0;
                count_next = '0;
                ovf_next   = 1'b0;
                err_next   = cfmp_pkg::ST_OK;
                idx_next   = '0;
                fpos_next  = '0;
            end
            else
            begin
                phase_next = phase_mid;
                up_next    = up_mid;
                lo_next    = lo_mid;
                long_next  = long_mid;
                count_next = count_mid;
                ovf_next   = ovf_mid;
                err_next   = err_mid;
                fpos_next  = fpos_mid;
                if (!in_none && idx_reg != IDX_MAX)
                    idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cfmp_pkg::PH_UPPER;
            up_reg    <= 5'd0;
            lo_reg    <= 5'd0;
            long_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            err_reg   <= cfmp_pkg::ST_OK;
            idx_reg   <= '0;
            fpos_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            up_reg    <= up_next;
            lo_reg    <= lo_next;
            long_reg  <= long_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            err_reg   <= err_next;
            idx_reg   <= idx_next;
            fpos_reg  <= fpos_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cfmp_queue.sv
// Command queue between parser and mass pipeline: two writes, one read per cycle.
// Depends on cfmp_pkg.
`default_nettype none

module cfmp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfmp_pkg::push_t     push,
    output logic                     ready,
    output logic                     head_valid,
    input  wire logic                pop,
    output cfmp_pkg::cmd_t           head
);

    cfmp_pkg::cmd_t                  entry_reg [cfmp_pkg::Q_DEPTH];
    logic [cfmp_pkg::Q_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [cfmp_pkg::Q_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [cfmp_pkg::Q_CW-1:0]       cnt_reg, cnt_next;
    logic [cfmp_pkg::Q_AW-1:0]       wr_b_ptr;
    logic                            do_pop;
    logic [cfmp_pkg::Q_CW-1:0]       n_push;

    // Keep room for a full pair of writes.
    assign ready      = cnt_reg <= cfmp_pkg::Q_CW'(cfmp_pkg::Q_DEPTH - 2);
    assign head_valid = cnt_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;
    assign wr_b_ptr   = push.a_en ? wr_ptr_reg + cfmp_pkg::Q_AW'(1) : wr_ptr_reg;
    assign n_push     = cfmp_pkg::Q_CW'(push.a_en) + cfmp_pkg::Q_CW'(push.b_en);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + cfmp_pkg::Q_AW'(n_push);
        rd_ptr_next = rd_ptr_reg + cfmp_pkg::Q_AW'(do_pop);
        cnt_next    = cnt_reg + n_push - cfmp_pkg::Q_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.a_en)
            entry_reg[wr_ptr_reg] <= push.a;
        if (push.b_en)
            entry_reg[wr_b_ptr] <= push.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cfmp_back.sv
// Mass pipeline: table lookup, split multiply, saturation, accumulate and result register.
// Depends on cfmp_pkg.
`default_nettype none

module cfmp_back #(
    parameter int FRACTION_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire cfmp_pkg::cmd_t                q_head,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cfmp_pkg::TOTAL_W-1:0]       out_total,
    output cfmp_pkg::status_t                  out_status,
    output logic [cfmp_pkg::POS_W-1:0]         out_pos
);

    localparam int PL_W = 32 + cfmp_pkg::COUNT_W;
    localparam int PH_W = cfmp_pkg::MASS_W - 32 + cfmp_pkg::COUNT_W;
    localparam int FULL_W = cfmp_pkg::TOTAL_W + 8;

    logic [cfmp_pkg::MASS_W-1:0]       mass_tab [cfmp_pkg::ELEM_COUNT];

    for (genvar g = 0; g < cfmp_pkg::ELEM_COUNT; g++)
    begin : g_mass
        localparam logic [cfmp_pkg::MASS_W-1:0] MASS_FX =
            cfmp_pkg::fixed_mass(cfmp_pkg::ELEM_SCALED[g], FRACTION_BITS);
        assign mass_tab[g] = MASS_FX;
    end

    logic                              adv;
    logic                              v2_reg, v3_reg, v4_reg;
    cfmp_pkg::cmd_t                    cmd2_reg, cmd3_reg, cmd4_reg;
    logic [cfmp_pkg::MASS_W-1:0]       mass2_reg, mass2_next;
    logic [PL_W-1:0]                   pl3_reg, pl3_next;
    logic [PH_W-1:0]                   ph3_reg, ph3_next;
    logic [FULL_W-1:0]                 full;
    logic [cfmp_pkg::TOTAL_W-1:0]      prod4_reg, prod4_next;
    logic [cfmp_pkg::TOTAL_W-1:0]      acc_reg, acc_next;
    logic [cfmp_pkg::TOTAL_W:0]        sum;
    logic [cfmp_pkg::TOTAL_W-1:0]      sum_sat;
    logic                              out_valid_reg, out_valid_next;
    logic [cfmp_pkg::TOTAL_W-1:0]      total_reg;
    cfmp_pkg::status_t                 status_reg;
    logic [cfmp_pkg::POS_W-1:0]        pos_reg;

    // Advance the whole pipeline unless a result is waiting and not taken.
    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;

    always_comb
    begin
        mass2_next = (q_head.elem < cfmp_pkg::ELEM_W'(cfmp_pkg::ELEM_COUNT))
                     ? mass_tab[q_head.elem] : '0;
        pl3_next   = mass2_reg[31:0] * cmd2_reg.count;
        ph3_next   = mass2_reg[cfmp_pkg::MASS_W-1:32] * cmd2_reg.count;
        full       = FULL_W'({ph3_reg, 32'b0}) + FULL_W'(pl3_reg);
        if (!cmd3_reg.add_en)
            prod4_next = '0;
        else if (full[FULL_W-1:cfmp_pkg::TOTAL_W] != '0)
            prod4_next = '1;
        else
            prod4_next = full[cfmp_pkg::TOTAL_W-1:0];
        sum     = {1'b0, acc_reg} + {1'b0, prod4_reg};
        sum_sat = sum[cfmp_pkg::TOTAL_W] ? '1 : sum[cfmp_pkg::TOTAL_W-1:0];
    end

    always_comb
    begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = v4_reg && cmd4_reg.fin;
            if (v4_reg)
                acc_next = cmd4_reg.fin ? '0 : sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd2_reg  <= q_head;
            mass2_reg <= mass2_next;
            cmd3_reg  <= cmd2_reg;
            pl3_reg   <= pl3_next;
            ph3_reg   <= ph3_next;
            cmd4_reg  <= cmd3_reg;
            prod4_reg <= prod4_next;
            if (v4_reg && cmd4_reg.fin)
            begin
                total_reg  <= (cmd4_reg.status == cfmp_pkg::ST_OK) ? sum_sat : '0;
                status_reg <= cmd4_reg.status;
                pos_reg    <= cmd4_reg.pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v2_reg <= q_valid;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_total  = total_reg;
    assign out_status = status_reg;
    assign out_pos    = pos_reg;

endmodule

`default_nettype wire

### rtl/core/chemical_formula_mass_parser.sv
// Top level of the chemical formula mass parser: stream ports, front end, queue, mass pipeline.
// Depends on cfmp_pkg, cfmp_front, cfmp_queue and cfmp_back.
`default_nettype none

// The block reads a formula such as "C6H12O6" one ASCII byte per item and returns one
// result item when the item marked with tlast arrives. Groups are an uppercase letter,
// at most one lowercase letter and an optional decimal count (default 1, at most
// 2^31-1); thirty common elements are known. The result carries the monoisotopic mass
// as unsigned fixed point with FRACTION_BITS fraction bits, saturating at all ones,
// and a status: ok, empty, unexpected character, unknown element, count too large or
// count zero. The first error wins; the mass reads zero for any status but ok, and the
// position field holds the index of the offending byte only for an unexpected
// character (indices saturate at MAX_LENGTH-1). An item with tuser set carries no byte;
// send one with tlast to close an empty formula. Rate: one item per clock cycle. The
// parser front end closes each group in the cycle its byte is taken and writes at most
// two commands per item into a four-entry queue; the mass pipeline behind it (table
// lookup, split multiply, saturation, accumulate) drains one command per cycle, so
// s_axis_tready falls only while a finished result is held up by m_axis_tready. The
// last command passes the queue entry and the lookup, multiply and saturation registers
// before the result register raises m_axis_tvalid; a group closed by that item goes first.
module chemical_formula_mass_parser #(
    parameter longint MAX_LENGTH    = 65536,
    parameter int     FRACTION_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
    input  wire logic        s_axis_tlast,   // last_character
    input  wire logic        s_axis_tuser,   // no_character
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // [63:0] formula_mass, [79:64] error_position
    output logic [2:0]       m_axis_tuser    // [2:0] status
);

    cfmp_pkg::push_t                     push;
    logic                                q_ready;
    logic                                q_valid;
    logic                                q_pop;
    cfmp_pkg::cmd_t                      q_head;
    logic [cfmp_pkg::TOTAL_W-1:0]        total;
    cfmp_pkg::status_t                   status;
    logic [cfmp_pkg::POS_W-1:0]          pos;

    // Front end: one byte per accepted item, commands out.
    cfmp_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (q_ready),
        .in_char  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .in_none  (s_axis_tuser),
        .push     (push)
    );

    // Queue: lets the front end keep taking items while the back end stalls briefly.
    cfmp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .ready      (q_ready),
        .head_valid (q_valid),
        .pop        (q_pop),
        .head       (q_head)
    );

    // Back end: mass arithmetic and the result register.
    cfmp_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_head     (q_head),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_total  (total),
        .out_status (status),
        .out_pos    (pos)
    );

    assign s_axis_tready = q_ready;
    assign m_axis_tdata  = {pos, total};
    assign m_axis_tuser  = status;

endmodule

`default_nettype wire

### rtl/core/cfmp_checker.sv
// Port-level checks for the chemical formula mass parser, bound to the top level.
// Depends on cfmp_pkg and chemical_formula_mass_parser.
`default_nettype none

module cfmp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    // Hold a stalled result unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A failed formula reports no mass.
    a_mass_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != 3'(cfmp_pkg::ST_OK) |->
            m_axis_tdata[63:0] == 64'd0)
        else $error("mass reported with an error status");

    // Position only accompanies an unexpected character.
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != 3'(cfmp_pkg::ST_BAD_CHAR) |->
            m_axis_tdata[79:64] == 16'd0)
        else $error("error position set without a character error");

endmodule

bind chemical_formula_mass_parser cfmp_checker u_cfmp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
